// ===== sv/swfe_pkg.sv =====
// ----------------------------------------------------------------------------
// swfe_pkg: shared types and constants for the sync word frame extractor
// Frame geometry, field widths and the word record passed to the output queue.
// ----------------------------------------------------------------------------
package swfe_pkg;

   // frame geometry
   localparam int FRAME_LEN = 26;
   localparam int BYTE_W    = 8;
   localparam int IDX_W     = 5;
   localparam int CSR_IDX_W = 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_FIRST  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_SECOND = 1'd1;

   // register reset values
   localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAA;
   localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h55;

   // output queue geometry
   localparam int OQ_DEPTH = 4;
   localparam int OQ_PTR_W = 2;
   localparam int OQ_CNT_W = 3;

   // one result word
   typedef struct packed {
      logic [BYTE_W-1:0] frame_byte;
      logic [IDX_W-1:0]  frame_index;
      logic              frame_last;
   } word_type;

   // up to two result words produced by one accepted byte
   typedef struct packed {
      logic     push0;
      logic     push1;
      word_type word0;
      word_type word1;
   } push_type;

endpackage

// ===== sv/swfe_framer.sv =====
// ----------------------------------------------------------------------------
// swfe_framer: sync hunt and frame position tracking
// Holds the sync registers and framing state, and turns each accepted byte
// into zero, one or two result words.
// ----------------------------------------------------------------------------
module swfe_framer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [swfe_pkg::BYTE_W-1:0]      rx_byte,
   input  logic                             csr_wr_en,
   input  logic [swfe_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [swfe_pkg::BYTE_W-1:0]      csr_wr_data,
   output swfe_pkg::push_type               push
);

   localparam logic SYNC_IS_LAST = (swfe_pkg::FRAME_LEN <= 2);

   logic [swfe_pkg::BYTE_W-1:0] sync_first_ff,  sync_first_in;
   logic [swfe_pkg::BYTE_W-1:0] sync_second_ff, sync_second_in;
   logic                        saw_first_ff,   saw_first_in;
   logic                        in_frame_ff,    in_frame_in;
   logic [swfe_pkg::IDX_W-1:0]  pos_ff,         pos_in;
   logic                        pos_last;

   // sync register writes
   always_comb begin
      sync_first_in  = sync_first_ff;
      sync_second_in = sync_second_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            swfe_pkg::CSR_SYNC_FIRST:  sync_first_in  = csr_wr_data;
            swfe_pkg::CSR_SYNC_SECOND: sync_second_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   // current word closes the frame
   assign pos_last = ({1'b0, pos_ff} + 6'd1) >= 6'(swfe_pkg::FRAME_LEN);

   // hunt / pass-through decode
   always_comb begin
      saw_first_in = saw_first_ff;
      in_frame_in  = in_frame_ff;
      pos_in       = pos_ff;
      push         = '0;
      push.word0   = '{frame_byte: rx_byte, frame_index: pos_ff, frame_last: pos_last};
      push.word1   = '{frame_byte: sync_second_ff,
                       frame_index: swfe_pkg::IDX_W'(1),
                       frame_last: SYNC_IS_LAST};
      if (accept) begin
         priority if (in_frame_ff) begin
            push.push0 = 1'b1;
            if (pos_last) begin
               in_frame_in  = 1'b0;
               saw_first_in = 1'b0;
               pos_in       = '0;
            end else begin
               pos_in = pos_ff + swfe_pkg::IDX_W'(1);
            end
         end else if (saw_first_ff && (rx_byte == sync_second_ff)) begin
            // pair complete: emit both sync words
            push.push0 = 1'b1;
            push.push1 = 1'b1;
            push.word0 = '{frame_byte: sync_first_ff, frame_index: '0, frame_last: 1'b0};
            saw_first_in = 1'b0;
            if (SYNC_IS_LAST) begin
               in_frame_in = 1'b0;
               pos_in      = '0;
            end else begin
               in_frame_in = 1'b1;
               pos_in      = swfe_pkg::IDX_W'(2);
            end
         end else begin
            saw_first_in = (rx_byte == sync_first_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= swfe_pkg::SYNC_FIRST_RST;
         sync_second_ff <= swfe_pkg::SYNC_SECOND_RST;
         saw_first_ff   <= 1'b0;
         in_frame_ff    <= 1'b0;
         pos_ff         <= '0;
      end else begin
         sync_first_ff  <= sync_first_in;
         sync_second_ff <= sync_second_in;
         saw_first_ff   <= saw_first_in;
         in_frame_ff    <= in_frame_in;
         pos_ff         <= pos_in;
      end
   end

endmodule

// ===== sv/swfe_out_queue.sv =====
// ----------------------------------------------------------------------------
// swfe_out_queue: result word queue
// Small queue that takes up to two words per cycle and hands out one word per
// cycle on the response channel while out_ready is high.
// ----------------------------------------------------------------------------
module swfe_out_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  swfe_pkg::push_type     push,
   output logic                   room,
   output logic                   out_valid,
   input  logic                   out_ready,
   output swfe_pkg::word_type     out_word
);

   swfe_pkg::word_type                 mem_ff [swfe_pkg::OQ_DEPTH];
   logic [swfe_pkg::OQ_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [swfe_pkg::OQ_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [swfe_pkg::OQ_CNT_W-1:0]      cnt_ff,    cnt_in;
   logic                               pop;
   logic [swfe_pkg::OQ_CNT_W-1:0]      n_push;
   logic [swfe_pkg::OQ_PTR_W-1:0]      wr_ptr_nx;

   // space for a full pair, judged on the registered count
   assign room      = cnt_ff <= swfe_pkg::OQ_CNT_W'(swfe_pkg::OQ_DEPTH - 2);
   assign out_valid = cnt_ff != '0;
   assign out_word  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   // pointer and count update
   always_comb begin
      n_push    = swfe_pkg::OQ_CNT_W'(push.push0) + swfe_pkg::OQ_CNT_W'(push.push1);
      wr_ptr_nx = wr_ptr_ff + swfe_pkg::OQ_PTR_W'(1);
      wr_ptr_in = wr_ptr_ff + n_push[swfe_pkg::OQ_PTR_W-1:0];
      rd_ptr_in = rd_ptr_ff + swfe_pkg::OQ_PTR_W'(pop);
      cnt_in    = cnt_ff + n_push - swfe_pkg::OQ_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (push.push0) begin
         mem_ff[wr_ptr_ff] <= push.word0;
      end
      if (push.push1) begin
         mem_ff[wr_ptr_nx] <= push.word1;
      end
   end

endmodule

// ===== sv/sync_word_frame_extractor.sv =====
// Words of an accepted byte are registered in the queue, then shown on rsp_.
// Throughput: one byte per cycle while req_ready is high; a completed sync
// pair gives two words; the 4-entry queue drains one per cycle on rsp_ready.
// req_ready drops while the queue holds more than two words.
// Reset (synchronous): hunting, queue empty, sync bytes 0xAA / 0x55.
// ----------------------------------------------------------------------------
// sync_word_frame_extractor: two-byte sync word deframer
// Hunts for the sync pair in the received byte stream and passes on fixed
// length frames with index and last marker.
// ----------------------------------------------------------------------------
module sync_word_frame_extractor (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [swfe_pkg::BYTE_W-1:0]      req_rx_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [swfe_pkg::BYTE_W-1:0]      rsp_frame_byte,
   output logic [swfe_pkg::IDX_W-1:0]       rsp_frame_index,
   output logic                             rsp_frame_last,
   input  logic                             csr_wr_en,
   input  logic [swfe_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [swfe_pkg::BYTE_W-1:0]      csr_wr_data
);

   swfe_pkg::push_type push;
   swfe_pkg::word_type out_word;
   logic               room;

   assign req_ready = room;

   swfe_framer u_framer (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_valid && room),
      .rx_byte     (req_rx_byte),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .push        (push)
   );

   swfe_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_word  (out_word)
   );

   assign rsp_frame_byte  = out_word.frame_byte;
   assign rsp_frame_index = out_word.frame_index;
   assign rsp_frame_last  = out_word.frame_last;

endmodule
